// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the gradient block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define CDG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define CDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cdg_pkg.sv
// Shared constants, types and helpers of the central-difference gradient block.
// No dependencies; used by every module of the block except cdg_ram.
package cdg_pkg;

  localparam int unsigned PixW        = 8;
  localparam int unsigned CfgW        = 12;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned RowW        = 11;
  localparam int unsigned ColW        = 11;
  localparam int unsigned GradW       = PixW + 1;
  localparam int unsigned EnergyW     = 17;
  localparam int unsigned DefMaxWidth = 2048;
  localparam int unsigned MaxHeight   = 2048;
  localparam int unsigned MinDim      = 3;
  localparam int unsigned ResetWidth  = 640;
  localparam int unsigned ResetHeight = 480;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

  typedef enum logic {
    PhFirst,
    PhBorder
  } cdg_phase_e;

  typedef struct packed {
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         col;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic                    two;
  } cdg_entry_t;

  function automatic logic [CfgW-1:0] clamp_dim(logic [CfgW-1:0] v, logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    r = v;
    if (v < CfgW'(MinDim)) begin
      r = CfgW'(MinDim);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cdg_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first on a same-address collision. No dependencies.
module cdg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cdg_fifo.sv
// Short result queue between the front and back of the gradient block.
// Depends on cdg_pkg for the entry type.
module cdg_fifo #(
  parameter int unsigned Depth = cdg_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cdg_pkg::cdg_entry_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output cdg_pkg::cdg_entry_t data_o
);
  import cdg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cdg_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push & ~do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop & ~do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/cdg_front.sv
// Front of the gradient block: configuration, raster counters, line buffer RAM,
// window and the central differences. Depends on cdg_pkg and cdg_ram.
module cdg_front #(
  parameter int unsigned MaxWidth = cdg_pkg::DefMaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [cdg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cdg_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                         cfg_ready_o,
  input  logic                         in_valid_i,
  input  logic [cdg_pkg::PixW-1:0]     pixel_value_i,
  input  logic                         frame_start_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output cdg_pkg::cdg_entry_t          push_data_o,
  input  logic                         q_full_i
);
  import cdg_pkg::*;

  localparam int unsigned AddrW   = $clog2(MaxWidth);
  localparam int unsigned CfgMax  = (1 << CfgW) - 1;
  localparam int unsigned WHi     = (MaxWidth > CfgMax) ? CfgMax : MaxWidth;
  localparam int unsigned WReset  = (ResetWidth > WHi) ? WHi : ResetWidth;
  localparam int unsigned CmpW    = ((AddrW > CfgW) ? AddrW : CfgW) + 1;

  logic [CfgW-1:0]  width_q, height_q;
  logic [AddrW-1:0] col_q, col_d, c0, cur_col;
  logic [RowW-1:0]  row_q, row_d, r0, cur_row;
  logic [CfgW-1:0]  r1, row_inc;
  logic [CmpW-1:0]  w_ext, col_next;
  logic             wrap_pre, end_row, emit, in_acc;

  logic             s1_valid_q, s1_emit_q, s1_zero_q, s1_two_q, s1_hit_q, s1_adv;
  logic [RowW-1:0]  s1_row_q;
  logic [ColW-1:0]  s1_col_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [PixW-1:0]  s1_pix_q;

  logic [2*PixW-1:0] ram_rdata, rd, fwd_q;
  logic [PixW-1:0]   mid_c, old_up;
  logic [PixW-1:0]   win1_q, win2_q, prev_pix_q, prev_up_q;
  logic signed [GradW-1:0] gx, gy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(WReset);
      height_q <= CfgW'(ResetHeight);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  width_q  <= clamp_dim(cfg_wdata_i, CfgW'(WHi));
        RegImageHeight: height_q <= clamp_dim(cfg_wdata_i, CfgW'(MaxHeight));
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel, then the position of the one after it.
  always_comb begin
    w_ext    = CmpW'(width_q);
    c0       = frame_start_i ? '0 : col_q;
    r0       = frame_start_i ? '0 : row_q;
    wrap_pre = (CmpW'(c0) >= w_ext);
    r1       = wrap_pre ? (CfgW'(r0) + CfgW'(1)) : CfgW'(r0);
    cur_row  = (r1 >= height_q) ? '0 : r1[RowW-1:0];
    cur_col  = wrap_pre ? '0 : c0;
    col_next = CmpW'(cur_col) + CmpW'(1);
    end_row  = (col_next >= w_ext);
    row_inc  = CfgW'(cur_row) + CfgW'(1);
    col_d    = end_row ? '0 : col_next[AddrW-1:0];
    if (end_row) begin
      row_d = (row_inc >= height_q) ? '0 : row_inc[RowW-1:0];
    end else begin
      row_d = cur_row;
    end
    emit = (cur_row >= RowW'(2)) && (cur_col >= AddrW'(1)) &&
           (CfgW'(cur_row) != height_q);
  end

  assign s1_adv     = s1_valid_q & ~(s1_emit_q & q_full_i);
  assign in_stall_o = s1_valid_q & s1_emit_q & q_full_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q <= emit;
      s1_zero_q <= (cur_col == AddrW'(1));
      s1_two_q  <= end_row;
      s1_row_q  <= cur_row - RowW'(1);
      s1_col_q  <= ColW'(cur_col - AddrW'(1));
      s1_addr_q <= cur_col;
      s1_pix_q  <= pixel_value_i;
      s1_hit_q  <= s1_valid_q & (cur_col == s1_addr_q);
    end
    if (s1_adv) begin
      fwd_q <= {mid_c, s1_pix_q};
    end
  end

  // Each word holds the row two above in its upper half and the row above in its lower half.
  cdg_ram #(
    .Width(2 * PixW),
    .Depth(MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i ({mid_c, s1_pix_q}),
    .re_i    (in_acc),
    .raddr_i (cur_col),
    .rdata_o (ram_rdata)
  );

  assign rd     = s1_hit_q ? fwd_q : ram_rdata;
  assign mid_c  = rd[PixW-1:0];
  assign old_up = rd[2*PixW-1:PixW];
  assign gx     = $signed({1'b0, mid_c}) - $signed({1'b0, win1_q});
  assign gy     = $signed({1'b0, prev_pix_q}) - $signed({1'b0, prev_up_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q     <= '0;
      win2_q     <= '0;
      prev_pix_q <= '0;
      prev_up_q  <= '0;
    end else if (s1_adv) begin
      win1_q     <= win2_q;
      win2_q     <= mid_c;
      prev_pix_q <= s1_pix_q;
      prev_up_q  <= old_up;
    end
  end

  assign push_o = s1_adv & s1_emit_q;

  always_comb begin
    push_data_o.row = s1_row_q;
    push_data_o.col = s1_col_q;
    push_data_o.gx  = s1_zero_q ? '0 : gx;
    push_data_o.gy  = s1_zero_q ? '0 : gy;
    push_data_o.two = s1_two_q;
  end

endmodule

// File: rtl/core/cdg_back.sv
// Back of the gradient block: energy, border result of the last column and the
// output register. Depends on cdg_pkg.
module cdg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  cdg_pkg::cdg_entry_t                 head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cdg_pkg::RowW-1:0]            out_row_o,
  output logic [cdg_pkg::ColW-1:0]            out_col_o,
  output logic signed [cdg_pkg::GradW-1:0]    grad_x_o,
  output logic signed [cdg_pkg::GradW-1:0]    grad_y_o,
  output logic [cdg_pkg::EnergyW-1:0]         grad_energy_o,
  output logic                                last_of_run_o
);
  import cdg_pkg::*;

  cdg_phase_e phase_q, phase_d;
  logic       out_valid_q, out_free, load, sel_border, last;
  logic signed [2*GradW-1:0] sq_x, sq_y;
  logic [2*GradW:0]          esum;

  logic [RowW-1:0]         row_q;
  logic [ColW-1:0]         col_q;
  logic signed [GradW-1:0] gx_q, gy_q;
  logic [EnergyW-1:0]      energy_q;
  logic                    last_q;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign load     = head_valid_i & out_free;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhFirst: begin
        if (load && head_i.two) begin
          phase_d = PhBorder;
        end
      end
      PhBorder: begin
        if (load) begin
          phase_d = PhFirst;
        end
      end
      default: phase_d = PhFirst;
    endcase
  end

  always_comb begin
    sel_border = (phase_q == PhBorder);
    last       = sel_border | ~head_i.two;
    pop_o      = load & last;
  end

  assign sq_x = $signed(head_i.gx) * $signed(head_i.gx);
  assign sq_y = $signed(head_i.gy) * $signed(head_i.gy);
  assign esum = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFirst;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q    <= head_i.row;
      col_q    <= sel_border ? (head_i.col + ColW'(1)) : head_i.col;
      gx_q     <= sel_border ? '0 : head_i.gx;
      gy_q     <= sel_border ? '0 : head_i.gy;
      energy_q <= sel_border ? '0 : EnergyW'(esum);
      last_q   <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign grad_x_o      = gx_q;
  assign grad_y_o      = gy_q;
  assign grad_energy_o = energy_q;
  assign last_of_run_o = last_q;

endmodule

// File: rtl/core/central_difference_gradient.sv
// Central-difference gradient of a raster-order gray image stream: top level.
// Depends on cdg_pkg, cdg_front, cdg_fifo and cdg_back.
//
// Unstalled, the block takes one pixel per clock and gives for each interior
// row the gradient of the pixel one row up and one column left of the pixel just
// taken: grad_x and grad_y are plain differences (one fractional bit) and
// grad_energy is the sum of their squares (two fractional bits). Border columns
// give zero results, border rows give none, and the pixel in the last column
// gives two results, the second being the zero border result. A result passes
// from the front's stage registers through the queue to the output register;
// the line buffer RAM, read and written once per pixel, sets the rate of one
// pixel per cycle, and the output register drains one result per cycle while
// out_stall_i is low, so a four-entry queue absorbs the extra row-end result.
// The line buffers have no reset and need no clearing pass; width and height are
// clamped to their legal ranges when written and may only be changed while the
// block is idle.
module central_difference_gradient #(
  parameter int unsigned MaxWidth = cdg_pkg::DefMaxWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cdg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cdg_pkg::CfgW-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cdg_pkg::PixW-1:0]            pixel_value_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cdg_pkg::RowW-1:0]            out_row_o,
  output logic [cdg_pkg::ColW-1:0]            out_col_o,
  output logic signed [cdg_pkg::GradW-1:0]    grad_x_o,
  output logic signed [cdg_pkg::GradW-1:0]    grad_y_o,
  output logic [cdg_pkg::EnergyW-1:0]         grad_energy_o,
  output logic                                last_of_run_o
);
  import cdg_pkg::*;

  logic       push, q_full, q_valid, pop;
  cdg_entry_t push_data, head;

  cdg_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cfg_ready_o   (cfg_ready_o),
    .in_valid_i    (in_valid_i),
    .pixel_value_i (pixel_value_i),
    .frame_start_i (frame_start_i),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .push_data_o   (push_data),
    .q_full_i      (q_full)
  );

  cdg_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head)
  );

  cdg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .grad_x_o      (grad_x_o),
    .grad_y_o      (grad_y_o),
    .grad_energy_o (grad_energy_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: rtl/core/cdg_checker.sv
// Port-level checks of the gradient block, bound to the top level.
// Depends on cdg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [cdg_pkg::RowW-1:0]            out_row_o,
  input logic [cdg_pkg::ColW-1:0]            out_col_o,
  input logic signed [cdg_pkg::GradW-1:0]    grad_x_o,
  input logic signed [cdg_pkg::GradW-1:0]    grad_y_o,
  input logic [cdg_pkg::EnergyW-1:0]         grad_energy_o,
  input logic                                last_of_run_o
);

  // A stalled result holds.
  property p_out_hold;
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_row_o) && $stable(out_col_o) && $stable(grad_x_o) &&
      $stable(grad_y_o) && $stable(grad_energy_o) && $stable(last_of_run_o);
  endproperty

  // The first of a pair is followed at once by the zero border result of the same row.
  property p_border_follows;
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && last_of_run_o && out_row_o == $past(out_row_o) &&
      out_col_o == $past(out_col_o) + 1'b1 &&
      grad_x_o == 0 && grad_y_o == 0 && grad_energy_o == 0;
  endproperty

  // The input side only stalls once results are backed up at the output.
  property p_stall_backs_up;
    in_stall_o |-> out_valid_o;
  endproperty

  // Zero differences give zero energy.
  property p_zero_energy;
    out_valid_o && grad_x_o == 0 && grad_y_o == 0 |-> grad_energy_o == 0;
  endproperty

  `CDG_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled result changed")
  `CDG_ASSERT(a_border_follows, clk_i, rst_ni, p_border_follows, "border result missing")
  `CDG_ASSERT(a_stall_backs_up, clk_i, rst_ni, p_stall_backs_up, "stall with empty output")
  `CDG_ASSERT_ALWAYS(a_zero_energy, clk_i, p_zero_energy, "energy not zero for zero gradient")

endmodule

bind central_difference_gradient cdg_checker u_cdg_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for central_difference_gradient: streams gray frames through the
// pixel channel, predicts every gradient result in the bench and checks each one.
// Depends on cdg_pkg and the central_difference_gradient RTL only.
module tb_top;
  import cdg_pkg::*;

  localparam int unsigned MaxW       = DefMaxWidth;
  localparam int unsigned RandPixels = 1700;
  localparam int unsigned EdgePixels = 300;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 10;

  localparam logic [7:0] DirFrame [15] = '{
    8'd0, 8'd0,   8'd255, 8'd0,   8'd0,
    8'd0, 8'd128, 8'd255, 8'd0,   8'd0,
    8'd0, 8'd255, 8'd0,   8'd255, 8'd0
  };

  typedef struct packed {
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         col;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic [EnergyW-1:0]      energy;
    logic                    last;
  } grad_result_t;

  typedef struct {
    logic [PixW-1:0] pix;
    logic            fs;
    logic            drain;
    int unsigned     gap;
  } pixel_item_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = RegImageWidth;
  logic [CfgW-1:0]         cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [PixW-1:0]         pixel_value_i = '0;
  logic                    frame_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [RowW-1:0]         out_row_o;
  logic [ColW-1:0]         out_col_o;
  logic signed [GradW-1:0] grad_x_o;
  logic signed [GradW-1:0] grad_y_o;
  logic [EnergyW-1:0]      grad_energy_o;
  logic                    last_of_run_o;

  central_difference_gradient dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .grad_x_o      (grad_x_o),
    .grad_y_o      (grad_y_o),
    .grad_energy_o (grad_energy_o),
    .last_of_run_o (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  // Bench copy of the block state and registers.
  logic [CfgW-1:0] width_reg = CfgW'(ResetWidth);
  logic [CfgW-1:0] height_reg = CfgW'(ResetHeight);
  bit [PixW-1:0]   upper_row_buf [MaxW];
  bit [PixW-1:0]   middle_row_buf [MaxW];
  int unsigned     row_pos = 0;
  int unsigned     col_pos = 0;
  bit [PixW-1:0]   mid_win [3];
  bit [PixW-1:0]   last_pix = '0;
  bit [PixW-1:0]   last_upper = '0;

  grad_result_t grad_expect_q [$];
  pixel_item_t  pend_q [$];

  int unsigned tx_mode = 1;
  int unsigned rx_mode = 1;
  pixel_item_t tx_cur = '{pix: '0, fs: 1'b0, drain: 1'b0, gap: 0};
  bit          tx_holding = 1'b0;
  bit          tx_offering = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;

  int unsigned pixels_queued = 0;
  int unsigned pixels_sent = 0;
  int unsigned frame_starts = 0;
  int unsigned results_seen = 0;
  int unsigned row_end_results = 0;
  int unsigned cfg_writes = 0;
  int unsigned settings = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic int unsigned dim_in_use(logic [CfgW-1:0] v, int unsigned hi);
    if (v < MinDim) begin
      return MinDim;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic int unsigned draw_gap(int unsigned mode);
    if (mode == 0) begin
      return 0;
    end else if (mode == 1) begin
      return $urandom_range(0, 7);
    end
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
  endfunction

  function automatic logic [PixW-1:0] rand_pixel();
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k == 0) begin
      return '0;
    end else if (k == 1) begin
      return '1;
    end
    return PixW'($urandom_range(0, 255));
  endfunction

  function automatic void predict_gradient(logic [PixW-1:0] pix, logic fs);
    int unsigned  w;
    int unsigned  h;
    int unsigned  r;
    int unsigned  c;
    int           dx;
    int           dy;
    bit [PixW-1:0] mid_c;
    bit [PixW-1:0] old_up;
    grad_result_t res;
    w = dim_in_use(width_reg, MaxW);
    h = dim_in_use(height_reg, MaxHeight);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) begin
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    mid_c = middle_row_buf[c];
    mid_win[0] = mid_win[1];
    mid_win[1] = mid_win[2];
    mid_win[2] = mid_c;
    if (r >= 2 && c >= 1 && r - 1 != h - 1) begin
      dx = 0;
      dy = 0;
      if (c - 1 != 0) begin
        dx = int'(mid_win[2]) - int'(mid_win[0]);
        dy = int'(last_pix) - int'(last_upper);
      end
      res.row    = RowW'(r - 1);
      res.col    = ColW'(c - 1);
      res.gx     = GradW'(dx);
      res.gy     = GradW'(dy);
      res.energy = EnergyW'(dx * dx + dy * dy);
      res.last   = (c != w - 1);
      grad_expect_q.push_back(res);
      if (c == w - 1) begin
        res.col    = ColW'(c);
        res.gx     = '0;
        res.gy     = '0;
        res.energy = '0;
        res.last   = 1'b1;
        grad_expect_q.push_back(res);
        row_end_results++;
      end
    end
    old_up = upper_row_buf[c];
    upper_row_buf[c] = mid_c;
    middle_row_buf[c] = pix;
    last_upper = old_up;
    last_pix = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) begin
        row_pos = 0;
      end
    end
  endfunction

  // Pixel sender.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_gradient(pixel_value_i, frame_start_i);
        pixels_sent++;
        if (frame_start_i) begin
          frame_starts++;
        end
        tx_offering = 1'b0;
      end
      if (!tx_offering && !tx_holding && pend_q.size() != 0) begin
        tx_cur = pend_q.pop_front();
        tx_holding = 1'b1;
        tx_gap = tx_cur.gap;
      end
      if (tx_holding && !(tx_cur.drain && grad_expect_q.size() != 0)) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else begin
          tx_holding = 1'b0;
          tx_offering = 1'b1;
        end
      end
      in_valid_i <= tx_offering;
      pixel_value_i <= tx_cur.pix;
      frame_start_i <= tx_cur.fs;
    end
  end

  // Result receiver and checker.
  always @(posedge clk_i) begin
    grad_result_t got;
    grad_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{out_row_o, out_col_o, grad_x_o, grad_y_o, grad_energy_o, last_of_run_o};
        results_seen++;
        if (grad_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb_top: unexpected result row %0d col %0d gx %0d gy %0d en %0d last %0d",
                     got.row, got.col, got.gx, got.gy, got.energy, got.last);
          end
        end else begin
          want = grad_expect_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.gx !== want.gx ||
              got.gy !== want.gy || got.energy !== want.energy || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb_top: expected row %0d col %0d gx %0d gy %0d en %0d last %0d",
                       want.row, want.col, want.gx, want.gy, want.energy, want.last);
              $display("tb_top:   actual row %0d col %0d gx %0d gy %0d en %0d last %0d",
                       got.row, got.col, got.gx, got.gy, got.energy, got.last);
            end
          end
        end
        rx_wait = draw_gap(rx_mode);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || tx_holding || tx_offering || grad_expect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegImageWidth) begin
      width_reg = data;
    end else begin
      height_reg = data;
    end
    cfg_writes++;
  endtask

  task automatic set_dims(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    wait_idle();
    cfg_write(RegImageWidth, w);
    cfg_write(RegImageHeight, h);
    settings++;
    @(negedge clk_i);
  endtask

  task automatic queue_pixel(logic [PixW-1:0] pix, logic fs, logic drain);
    pixel_item_t it;
    it.pix = pix;
    it.fs = fs;
    it.drain = drain;
    it.gap = draw_gap(tx_mode);
    pend_q.push_back(it);
    pixels_queued++;
  endtask

  initial begin
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned len;
    int unsigned kind;
    int unsigned restart_at;
    int unsigned nframes;
    int unsigned phase_no;
    logic [CfgW-1:0] w_reg;
    logic [CfgW-1:0] h_reg;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme gradients, a frame wrap without frame_start, then a narrower
    // width while the column counter already sits past the new end of row.
    tx_mode = 1;
    rx_mode = 1;
    set_dims(CfgW'(5), CfgW'(0));
    for (int i = 0; i < 15; i++) begin
      queue_pixel(DirFrame[i], i == 0, 1'b0);
    end
    for (int i = 0; i < 3; i++) begin
      queue_pixel(rand_pixel(), 1'b0, i == 0);
    end
    wait_idle();
    cfg_write(RegImageWidth, CfgW'(3));
    @(negedge clk_i);
    for (int i = 0; i < 6; i++) begin
      queue_pixel(rand_pixel(), 1'b0, 1'b0);
    end

    phase_no = 0;
    while (pixels_queued < RandPixels - 2 * EdgePixels) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        w_reg = CfgW'($urandom_range(0, 2));
      end else if (kind == 1) begin
        w_reg = CfgW'($urandom_range(13, 40));
      end else begin
        w_reg = CfgW'($urandom_range(3, 12));
      end
      h_reg = ($urandom_range(0, 4) == 0) ? CfgW'($urandom_range(0, 2))
                                           : CfgW'($urandom_range(3, 6));
      if (phase_no == 0) begin
        w_reg = CfgW'(10);
        h_reg = CfgW'(5);
      end
      set_dims(w_reg, h_reg);
      tx_mode = (phase_no == 0) ? 0 : $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      w_eff = dim_in_use(w_reg, MaxW);
      h_eff = dim_in_use(h_reg, MaxHeight);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes && pixels_queued < RandPixels - 2 * EdgePixels; f++) begin
        kind = $urandom_range(0, 9);
        len = w_eff * h_eff;
        if (kind == 0) begin
          len = $urandom_range(1, len);
        end else if (kind == 1) begin
          len = len + $urandom_range(1, 2 * w_eff);
        end
        restart_at = (kind == 2) ? $urandom_range(1, len) : len;
        for (int i = 0; i < len; i++) begin
          queue_pixel(rand_pixel(), i == 0 || i == restart_at,
                      i == 0 && f != 0 && $urandom_range(0, 3) == 0);
        end
      end
      if (phase_no == 0) begin
        @(posedge clk_i);
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      phase_no++;
    end

    // A long run at the widest width, then many rows at the largest height.
    set_dims(CfgW'(4095), CfgW'(3));
    tx_mode = 0;
    rx_mode = 2;
    for (int i = 0; i < EdgePixels; i++) begin
      queue_pixel(rand_pixel(), i == 0, 1'b0);
    end
    set_dims(CfgW'(3), CfgW'(4095));
    for (int i = 0; i < EdgePixels; i++) begin
      queue_pixel(rand_pixel(), i == 0, 1'b0);
    end

    wait_idle();
    mismatches += grad_expect_q.size();
    $display("tb_top: %0d pixels sent in %0d frame starts, %0d results checked (%0d row ends)",
             pixels_sent, frame_starts, results_seen, row_end_results);
    $display("tb_top: %0d register writes over %0d size settings, %0d mismatches",
             cfg_writes, settings, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cdg_pkg.sv
rtl/core/cdg_ram.sv
rtl/core/cdg_fifo.sv
rtl/core/cdg_front.sv
rtl/core/cdg_back.sv
rtl/core/central_difference_gradient.sv
rtl/core/cdg_checker.sv
bench/tb_top.sv
